@@ rtl/core/tca_pkg.sv @@
// Shared types, widths and constants for the triangle classifier.
// Used by every module of the block; depends on nothing else.
package tca_pkg;

    localparam int SIDE_BITS    = 16;
    localparam int DEN_W        = SIDE_BITS + 2;
    localparam int DIV_BITS     = 30;
    localparam int PROD_W       = 2 * DIV_BITS;
    localparam int SQRT_BITS    = 31;
    localparam int SQRT_IN_W    = 2 * SQRT_BITS;
    localparam int SQRT_REM_W   = SQRT_BITS + 3;
    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;
    localparam int ZW           = 29;
    localparam int ATAN_W       = 27;
    localparam int ANGLE_W      = 15;
    localparam int ANGLE_LAT    = DIV_BITS + SQRT_BITS + CORDIC_STEPS + 3;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 15'd18000;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_EQUI    = 2'd1;
    localparam logic [1:0] KIND_ISO     = 2'd2;
    localparam logic [1:0] KIND_SCALENE = 2'd3;

    // atan(2^-i) in units of 2^-20 degree
    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
        27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
        27'd234682,   27'd117342,   27'd58671,    27'd29335,
        27'd14668,    27'd7334,     27'd3667,     27'd1833,
        27'd917,      27'd458,      27'd229,      27'd115,
        27'd57,       27'd29,       27'd14,       27'd7
    };

    typedef struct packed {
        logic [SIDE_BITS-1:0] side_a;
        logic [SIDE_BITS-1:0] side_b;
        logic [SIDE_BITS-1:0] side_c;
    } side_word_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ANGLE_W-1:0] angle_a;
        logic [ANGLE_W-1:0] angle_b;
        logic [ANGLE_W-1:0] angle_c;
    } result_word_t;

    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctl_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] kind;
    } meta_t;

    // arithmetic shift that truncates toward zero
    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                   input int k);
        logic [CW-1:0] mag;
        begin
            mag = v[CW-1] ? (-v) : v;
            mag = mag >> k;
            shr_tz = v[CW-1] ? -mag : mag;
        end
    endfunction

endpackage

@@ rtl/core/triangle_classify_and_angles.sv @@
// Triangle classifier with law-of-cosines angles.
// Depends on tca_pkg and tca_angle.
//
// Usage:
//   The sides channel (sides_valid / sides_ready / sides) takes one word of
//   three side lengths. The result channel (result_valid / result_ready /
//   result) returns one word per input word, in order: the kind code and the
//   three angles in hundredths of a degree. A non-triangle gives kind zero
//   and zero angles.
//   Throughput is one word per cycle while sides_ready is high. Each word
//   passes through ANGLE_LAT + 2 registers on its way to result_valid:
//   an input register, 30 divider stages, product and rounding registers,
//   31 square-root stages, 24 CORDIC stages, a scaling register and the
//   output register.
//   The whole pipeline advances together; a skid register behind it catches
//   the one word in flight when the receiver stalls, and sides_ready drops
//   until the skid register drains, so nothing is lost or repeated.
//   Reset clears all valid bits; the block holds no state between words.
module triangle_classify_and_angles (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sides_valid,
    output logic                  sides_ready,
    input  tca_pkg::side_word_t   sides,
    output logic                  result_valid,
    input  logic                  result_ready,
    output tca_pkg::result_word_t result
);
    import tca_pkg::*;

    logic en;

    logic                 s0_vld_reg;
    logic [SIDE_BITS-1:0] s0_a_reg;
    logic [SIDE_BITS-1:0] s0_b_reg;
    logic [SIDE_BITS-1:0] s0_c_reg;
    meta_t                s0_meta_reg;
    meta_t                s0_meta_next;

    meta_t meta_reg [ANGLE_LAT];

    pipe_ctl_t          ang_ctl;
    logic               aa_vld;
    logic               ab_vld;
    logic [ANGLE_W-1:0] aa;
    logic [ANGLE_W-1:0] ab;

    logic         fin_vld;
    result_word_t fin;
    logic [15:0]  sum_ab;

    logic         out_vld_reg;
    result_word_t out_reg;
    logic         skid_vld_reg;
    result_word_t skid_reg;

    assign en          = !skid_vld_reg;
    assign sides_ready = en;

    // validity and kind from the raw sides
    always_comb
    begin
        logic [SIDE_BITS:0] a;
        logic [SIDE_BITS:0] b;
        logic [SIDE_BITS:0] c;
        a = {1'b0, sides.side_a};
        b = {1'b0, sides.side_b};
        c = {1'b0, sides.side_c};
        s0_meta_next.ok = (a != '0) && (b != '0) && (c != '0) &&
                          (a < b + c) && (b < a + c) && (c < a + b);
        priority if (!s0_meta_next.ok)
            s0_meta_next.kind = KIND_NONE;
        else if ((a == b) && (b == c))
            s0_meta_next.kind = KIND_EQUI;
        else if ((a == b) || (a == c) || (b == c))
            s0_meta_next.kind = KIND_ISO;
        else
            s0_meta_next.kind = KIND_SCALENE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (en)
            s0_vld_reg <= sides_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_a_reg    <= sides.side_a;
            s0_b_reg    <= sides.side_b;
            s0_c_reg    <= sides.side_c;
            s0_meta_reg <= s0_meta_next;
            meta_reg[0] <= s0_meta_reg;
            for (int i = 1; i < ANGLE_LAT; i++)
                meta_reg[i] <= meta_reg[i-1];
        end
    end

    assign ang_ctl = '{en: en, vld: s0_vld_reg};

    tca_angle u_angle_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ang_ctl),
        .opp       (s0_a_reg),
        .adj_p     (s0_b_reg),
        .adj_q     (s0_c_reg),
        .angle_vld (aa_vld),
        .angle     (aa)
    );

    tca_angle u_angle_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ang_ctl),
        .opp       (s0_b_reg),
        .adj_p     (s0_a_reg),
        .adj_q     (s0_c_reg),
        .angle_vld (ab_vld),
        .angle     (ab)
    );

    assign fin_vld = aa_vld & ab_vld;
    assign sum_ab  = {1'b0, aa} + {1'b0, ab};

    always_comb
    begin
        fin.kind = meta_reg[ANGLE_LAT-1].kind;
        if (!meta_reg[ANGLE_LAT-1].ok)
        begin
            fin.angle_a = '0;
            fin.angle_b = '0;
            fin.angle_c = '0;
        end
        else
        begin
            fin.angle_a = aa;
            fin.angle_b = ab;
            if (sum_ab >= 16'(ANGLE_MAX))
                fin.angle_c = '0;
            else
                fin.angle_c = ANGLE_MAX - sum_ab[ANGLE_W-1:0];
        end
    end

    // output register plus skid; skid only fills when the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (result_ready)
                skid_vld_reg <= 1'b0;
        end
        else if (fin_vld)
        begin
            if (!out_vld_reg || result_ready)
                out_vld_reg <= 1'b1;
            else
                skid_vld_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (result_ready)
                out_reg <= skid_reg;
        end
        else if (fin_vld)
        begin
            if (!out_vld_reg || result_ready)
                out_reg <= fin;
            else
                skid_reg <= fin;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

@@ rtl/core/tca_div.sv @@
// Restoring divider, one quotient bit per register stage.
// Depends on tca_pkg.
module tca_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tca_pkg::pipe_ctl_t        ctl,
    input  logic [tca_pkg::DEN_W-1:0] num,
    input  logic [tca_pkg::DEN_W-1:0] den,
    output logic                      quot_vld,
    output logic [tca_pkg::DIV_BITS-1:0] quot
);
    import tca_pkg::*;

    logic [DEN_W-1:0]    rem_reg  [DIV_BITS];
    logic [DEN_W-1:0]    den_reg  [DIV_BITS];
    logic [DIV_BITS-1:0] quot_reg [DIV_BITS];
    logic [DIV_BITS-1:0] vld_reg;

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_stage
        logic [DEN_W-1:0]    rem_in;
        logic [DEN_W-1:0]    den_in;
        logic [DIV_BITS-1:0] quot_in;
        logic                vld_in;
        logic [DEN_W:0]      trial;
        logic [DEN_W:0]      diff;

        if (k == 0)
        begin : g_first
            assign rem_in  = num;
            assign den_in  = den;
            assign quot_in = '0;
            assign vld_in  = ctl.vld;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign trial = {rem_in, 1'b0};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (ctl.en)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                if (trial >= {1'b0, den_in})
                begin
                    rem_reg[k]  <= diff[DEN_W-1:0];
                    quot_reg[k] <= {quot_in[DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= trial[DEN_W-1:0];
                    quot_reg[k] <= {quot_in[DIV_BITS-2:0], 1'b0};
                end
                den_reg[k] <= den_in;
            end
        end
    end

    assign quot     = quot_reg[DIV_BITS-1];
    assign quot_vld = vld_reg[DIV_BITS-1];

endmodule

@@ rtl/core/tca_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per register stage.
// Depends on tca_pkg.
module tca_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tca_pkg::pipe_ctl_t            ctl,
    input  logic [tca_pkg::SQRT_IN_W-1:0] rad,
    output logic                          root_vld,
    output logic [tca_pkg::SQRT_BITS-1:0] root
);
    import tca_pkg::*;

    logic [SQRT_IN_W-1:0]  rad_reg  [SQRT_BITS];
    logic [SQRT_REM_W-1:0] rem_reg  [SQRT_BITS];
    logic [SQRT_BITS-1:0]  root_reg [SQRT_BITS];
    logic [SQRT_BITS-1:0]  vld_reg;

    for (genvar j = 0; j < SQRT_BITS; j++)
    begin : g_stage
        logic [SQRT_IN_W-1:0]  rad_in;
        logic [SQRT_REM_W-1:0] rem_in;
        logic [SQRT_BITS-1:0]  root_in;
        logic                  vld_in;
        logic [SQRT_REM_W-1:0] rem_sh;
        logic [SQRT_REM_W-1:0] trial;

        if (j == 0)
        begin : g_first
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign vld_in  = ctl.vld;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign vld_in  = vld_reg[j-1];
        end

        // bring down the next pair of radicand bits
        assign rem_sh = {rem_in[SQRT_REM_W-3:0], rad_in[SQRT_IN_W-1-2*j -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (ctl.en)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg[j]  <= rem_sh - trial;
                    root_reg[j] <= {root_in[SQRT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j]  <= rem_sh;
                    root_reg[j] <= {root_in[SQRT_BITS-2:0], 1'b0};
                end
                rad_reg[j] <= rad_in;
            end
        end
    end

    assign root     = root_reg[SQRT_BITS-1];
    assign root_vld = vld_reg[SQRT_BITS-1];

endmodule

@@ rtl/core/tca_cordic.sv @@
// Vectoring CORDIC, one micro-rotation per register stage, gives atan2(y, x).
// Depends on tca_pkg.
module tca_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tca_pkg::pipe_ctl_t            ctl,
    input  logic [tca_pkg::SQRT_BITS-1:0] x0,
    input  logic [tca_pkg::SQRT_BITS-1:0] y0,
    output logic                          z_vld,
    output logic signed [tca_pkg::ZW-1:0] z
);
    import tca_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] vld_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_stage
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic                 vld_in;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [ZW-1:0] ang;

        if (i == 0)
        begin : g_first
            assign x_in   = signed'({{(CW-SQRT_BITS){1'b0}}, x0});
            assign y_in   = signed'({{(CW-SQRT_BITS){1'b0}}, y0});
            assign z_in   = '0;
            assign vld_in = ctl.vld;
        end
        else
        begin : g_next
            assign x_in   = x_reg[i-1];
            assign y_in   = y_reg[i-1];
            assign z_in   = z_reg[i-1];
            assign vld_in = vld_reg[i-1];
        end

        assign xs  = shr_tz(x_in, i);
        assign ys  = shr_tz(y_in, i);
        assign ang = signed'({{(ZW-ATAN_W){1'b0}}, ATAN_TAB[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (ctl.en)
                vld_reg[i] <= vld_in;
        end

        // rotate toward y = 0; zero counts as not positive
        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                if (y_in > 0)
                begin
                    x_reg[i] <= x_in + ys;
                    y_reg[i] <= y_in - xs;
                    z_reg[i] <= z_in + ang;
                end
                else
                begin
                    x_reg[i] <= x_in - ys;
                    y_reg[i] <= y_in + xs;
                    z_reg[i] <= z_in - ang;
                end
            end
        end
    end

    assign z     = z_reg[CORDIC_STEPS-1];
    assign z_vld = vld_reg[CORDIC_STEPS-1];

endmodule

@@ rtl/core/tca_angle.sv @@
// One angle path: two divides, product, square roots, CORDIC and scaling.
// Depends on tca_pkg, tca_div, tca_sqrt and tca_cordic.
module tca_angle (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tca_pkg::pipe_ctl_t            ctl,
    input  logic [tca_pkg::SIDE_BITS-1:0] opp,
    input  logic [tca_pkg::SIDE_BITS-1:0] adj_p,
    input  logic [tca_pkg::SIDE_BITS-1:0] adj_q,
    output logic                          angle_vld,
    output logic [tca_pkg::ANGLE_W-1:0]   angle
);
    import tca_pkg::*;

    localparam logic [DIV_BITS:0]  ONE_Q30  = (DIV_BITS+1)'(1) << DIV_BITS;
    localparam logic [PROD_W:0]    HALF_Q30 = (PROD_W+1)'(1) << (DIV_BITS-1);
    localparam logic [35:0]        ROUND_Z  = 36'd1 << 19;

    logic [DEN_W-1:0] num_u;
    logic [DEN_W-1:0] den_u;
    logic [DEN_W-1:0] num_v;
    logic [DEN_W-1:0] den_v;

    logic                u_vld;
    logic                v_vld;
    logic [DIV_BITS-1:0] u_q;
    logic [DIV_BITS-1:0] v_q;

    logic              prod_vld_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              r_vld_reg;
    logic [DIV_BITS:0] r_reg;
    logic [PROD_W:0]   prod_rnd;
    logic [DIV_BITS:0] r_next;
    logic [DIV_BITS:0] rc;

    logic                 s_vld;
    logic                 c_vld;
    logic [SQRT_BITS-1:0] s_root;
    logic [SQRT_BITS-1:0] c_root;

    logic                 z_vld;
    logic signed [ZW-1:0] z;
    logic [35:0]          zs;
    logic [15:0]          h;
    logic [ANGLE_W-1:0]   angle_next;
    logic                 angle_vld_reg;
    logic [ANGLE_W-1:0]   angle_reg;

    pipe_ctl_t div_ctl;
    pipe_ctl_t sqrt_ctl;
    pipe_ctl_t cordic_ctl;

    assign num_u = {2'b00, opp} + {2'b00, adj_q} - {2'b00, adj_p};
    assign den_u = {1'b0, adj_q, 1'b0};
    assign num_v = {2'b00, opp} + {2'b00, adj_p} - {2'b00, adj_q};
    assign den_v = {1'b0, adj_p, 1'b0};

    assign div_ctl = '{en: ctl.en, vld: ctl.vld};

    tca_div u_div_u (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .num      (num_u),
        .den      (den_u),
        .quot_vld (u_vld),
        .quot     (u_q)
    );

    tca_div u_div_v (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .num      (num_v),
        .den      (den_v),
        .quot_vld (v_vld),
        .quot     (v_q)
    );

    // round the Q60 product back to Q30, saturate at one
    assign prod_rnd = {1'b0, prod_reg} + HALF_Q30;
    always_comb
    begin
        r_next = prod_rnd[PROD_W:DIV_BITS];
        if (r_next > ONE_Q30)
            r_next = ONE_Q30;
    end
    assign rc = ONE_Q30 - r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            r_vld_reg    <= 1'b0;
        end
        else if (ctl.en)
        begin
            prod_vld_reg <= u_vld & v_vld;
            r_vld_reg    <= prod_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg <= PROD_W'(u_q) * PROD_W'(v_q);
            r_reg    <= r_next;
        end
    end

    assign sqrt_ctl = '{en: ctl.en, vld: r_vld_reg};

    tca_sqrt u_sqrt_s (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sqrt_ctl),
        .rad      ({1'b0, r_reg, {DIV_BITS{1'b0}}}),
        .root_vld (s_vld),
        .root     (s_root)
    );

    tca_sqrt u_sqrt_c (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sqrt_ctl),
        .rad      ({1'b0, rc, {DIV_BITS{1'b0}}}),
        .root_vld (c_vld),
        .root     (c_root)
    );

    assign cordic_ctl = '{en: ctl.en, vld: s_vld & c_vld};

    tca_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cordic_ctl),
        .x0    (c_root),
        .y0    (s_root),
        .z_vld (z_vld),
        .z     (z)
    );

    // z is in 2^-20 degree; scale to hundredths, round half up
    assign zs = 36'(z[ZW-2:0]) * 36'd200 + ROUND_Z;
    assign h  = zs[35:20];
    always_comb
    begin
        if (z[ZW-1] || (z == '0))
            angle_next = '0;
        else if (h > 16'(ANGLE_MAX))
            angle_next = ANGLE_MAX;
        else
            angle_next = h[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            angle_vld_reg <= 1'b0;
        else if (ctl.en)
            angle_vld_reg <= z_vld;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
            angle_reg <= angle_next;
    end

    assign angle_vld = angle_vld_reg;
    assign angle     = angle_reg;

endmodule

@@ rtl/core/tca_checker.sv @@
// Port-level checks for the triangle classifier, bound to the top level.
// Depends on tca_pkg and triangle_classify_and_angles.
module tca_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  sides_valid,
    input logic                  sides_ready,
    input tca_pkg::side_word_t   sides,
    input logic                  result_valid,
    input logic                  result_ready,
    input tca_pkg::result_word_t result
);
    import tca_pkg::*;

    logic [16:0] sum_ab;
    logic [16:0] sum_abc;

    assign sum_ab  = {2'b00, result.angle_a} + {2'b00, result.angle_b};
    assign sum_abc = sum_ab + {2'b00, result.angle_c};

    // a non-triangle carries no angles
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_NONE) |->
            (result.angle_a == '0) && (result.angle_b == '0) && (result.angle_c == '0))
        else $error("non-triangle word with nonzero angle");

    // angles sum to exactly a half turn, unless the third one saturates at zero
    a_sum_half_turn: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind != KIND_NONE) |->
            (sum_abc == 17'd18000) ||
            ((result.angle_c == '0) && (sum_ab >= 17'd18000)))
        else $error("angles do not sum to a half turn");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.angle_a <= ANGLE_MAX) && (result.angle_b <= ANGLE_MAX))
        else $error("angle beyond half turn");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result word changed or dropped");

endmodule

bind triangle_classify_and_angles tca_checker u_tca_checker (.*);
